// ----- sv/crd_pkg.sv -----
// ----------------------------------------------------------------------------
// crd_pkg
// shared types, widths, reset values and register codes of the compression
// rate detector
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int THRESH_W = 15;
    localparam int GROUP_W  = 8;
    localparam int NUMER_W  = 20;
    localparam int FALL_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NUMER_W;
    localparam int DIV_CNT_W  = $clog2(NUMER_W + 1);

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(2816);
    localparam logic [GROUP_W-1:0]  GROUP_RESET  = GROUP_W'(25);
    localparam logic [NUMER_W-1:0]  NUMER_RESET  = NUMER_W'(600000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_NUMERATOR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } crd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic eval;      // update detector state
        logic div_step;  // one quotient bit
        logic emit;      // move result into the output register
    } crd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;  // group completed with a nonzero span
        logic div_last;  // final quotient bit this cycle
    } crd_status_t;

endpackage

`default_nettype wire

// ----- sv/crd_ctrl.sv -----
// ----------------------------------------------------------------------------
// crd_ctrl
// sequencer: accept an item, evaluate it, run the divider when a group
// closes with a nonzero span, then hand the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module crd_ctrl
    import crd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic        out_free,
    input  wire crd_status_t status,
    output logic             in_ready,
    output crd_cmd_t         cmd
);

    crd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = status.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EVAL: cmd.eval = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_EMIT: cmd.emit = out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/crd_datapath.sv -----
// ----------------------------------------------------------------------------
// crd_datapath
// detector state, group timing and a restoring divider, one quotient bit
// per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module crd_datapath
    import crd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire crd_cmd_t                   cmd,
    input  wire logic signed [SAMPLE_W-1:0] in_sample,
    input  wire logic [TIME_W-1:0]          in_timestamp,
    input  wire logic [THRESH_W-1:0]        fall_threshold,
    input  wire logic [GROUP_W-1:0]         group_size,
    input  wire logic [NUMER_W-1:0]         rate_numerator,
    output crd_status_t                     status,
    output logic                            seen,
    output logic                            updated,
    output logic [NUMER_W-1:0]              rate
);

    // captured item
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic [TIME_W-1:0]          now_reg;

    // detector state
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [FALL_W-1:0]          fall_count_reg;
    logic [GROUP_W-1:0]         comp_count_reg;
    logic [TIME_W-1:0]          start_time_reg;
    logic [NUMER_W-1:0]         held_rate_reg;
    logic                       seen_reg;
    logic                       updated_reg;

    // divider
    logic [TIME_W-1:0]    span_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [NUMER_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [SAMPLE_W:0]   mag;
    logic                fall_hit;
    logic [FALL_W-1:0]   fall_upd;
    logic                seen_now;
    logic [GROUP_W-1:0]  count_inc;
    logic                group_first;
    logic                group_done;
    logic [TIME_W-1:0]   start_eff;
    logic [TIME_W-1:0]   span_now;
    logic [TIME_W:0]     rem_shift;
    logic [TIME_W+1:0]   diff;
    logic                q_bit;
    logic [NUMER_W-1:0]  quo_next;

    always_comb begin
        mag = cur_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {cur_reg[SAMPLE_W-1], cur_reg})
                                  : {1'b0, cur_reg};
        fall_hit = (cur_reg < prev_reg) && (mag > {2'b00, fall_threshold});
        fall_upd = (fall_hit && (fall_count_reg != '1)) ? fall_count_reg + 1'b1
                                                        : fall_count_reg;
        seen_now    = (cur_reg > prev_reg) && (fall_upd > FALL_W'(1));
        count_inc   = comp_count_reg + 1'b1;
        group_first = (count_inc == GROUP_W'(1));
        group_done  = (count_inc >= group_size);
        start_eff   = group_first ? now_reg : start_time_reg;
        span_now    = now_reg - start_eff;

        rem_shift = {rem_reg, quo_reg[NUMER_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, span_reg};
        q_bit     = !diff[TIME_W+1];
        quo_next  = {quo_reg[NUMER_W-2:0], q_bit};

        status.need_div = seen_now && group_done && (span_now != '0);
        status.div_last = (div_cnt_reg == DIV_CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= in_sample;
            now_reg <= in_timestamp;
        end
        if (cmd.eval) begin
            span_reg <= span_now;
            rem_reg  <= '0;
            quo_reg  <= rate_numerator;
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            fall_count_reg <= '0;
            comp_count_reg <= '0;
            start_time_reg <= '0;
            held_rate_reg  <= '0;
            seen_reg       <= 1'b0;
            updated_reg    <= 1'b0;
            div_cnt_reg    <= '0;
        end else begin
            if (cmd.eval) begin
                prev_reg       <= cur_reg;
                fall_count_reg <= seen_now ? '0 : fall_upd;
                seen_reg       <= seen_now;
                updated_reg    <= seen_now && group_done;
                div_cnt_reg    <= DIV_CNT_W'(NUMER_W);
                if (seen_now) begin
                    comp_count_reg <= group_done ? '0 : count_inc;
                    start_time_reg <= start_eff;
                    if (group_done && (span_now == '0)) begin
                        held_rate_reg <= rate_numerator;
                    end
                end
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (status.div_last) begin
                    held_rate_reg <= quo_next;
                end
            end
        end
    end

    assign seen    = seen_reg;
    assign updated = updated_reg;
    assign rate    = held_rate_reg;

    // a compression always clears the fall counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval && seen_now) |=> (fall_count_reg == '0))
        else $error("fall counter not cleared after compression");

    // the divider never steps past its last bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (div_cnt_reg != '0))
        else $error("divider stepped with no bits left");

    // a recompute always closes the group
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval && seen_now && group_done) |=> (comp_count_reg == '0))
        else $error("group count not restarted");

endmodule

`default_nettype wire

// ----- sv/compression_rate_detector_unit.sv -----
// timing: an item passes the idle (load), eval and emit states; when a group closes
//   with a nonzero span the 20-bit restoring divider runs in the div state between
//   eval and emit; emit waits for a free output register, and no new item is taken
//   until the result of the last one has been emitted
// reset: synchronous active-low aresetn clears all detector state and loads
//   register defaults (threshold 11.0, group of 25, numerator 600000)
// ----------------------------------------------------------------------------
// compression_rate_detector_unit
// detects compressions from acceleration samples and derives a rate from the
// duration of each group of compressions
// ----------------------------------------------------------------------------
`default_nettype none

module compression_rate_detector_unit
    import crd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [47:0]           s_tdata,   // [15:0] sample, [47:16] timestamp_ms

    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [19:0] rate, [23:20] zero
    output logic [1:0]                 m_tuser,   // [0] compression_seen, [1] rate_updated

    // register writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [THRESH_W-1:0] fall_threshold_reg;
    logic [GROUP_W-1:0]  group_size_reg;
    logic [NUMER_W-1:0]  rate_numerator_reg;

    // output register
    logic                m_tvalid_reg;
    logic                m_seen_reg;
    logic                m_updated_reg;
    logic [NUMER_W-1:0]  m_rate_reg;

    crd_cmd_t    cmd;
    crd_status_t status;
    logic        out_free;
    logic        dp_seen;
    logic        dp_updated;
    logic [NUMER_W-1:0] dp_rate;

    // writes are always taken; an index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fall_threshold_reg <= THRESH_RESET;
            group_size_reg     <= GROUP_RESET;
            rate_numerator_reg <= NUMER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FALL_THRESHOLD: fall_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_GROUP_SIZE:     group_size_reg     <= cfg_data[GROUP_W-1:0];
                REG_RATE_NUMERATOR: rate_numerator_reg <= cfg_data[NUMER_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    crd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // detector state and divider
    crd_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_sample      (s_tdata[SAMPLE_W-1:0]),
        .in_timestamp   (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
        .fall_threshold (fall_threshold_reg),
        .group_size     (group_size_reg),
        .rate_numerator (rate_numerator_reg),
        .status         (status),
        .seen           (dp_seen),
        .updated        (dp_updated),
        .rate           (dp_rate)
    );

    // the output register can take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_seen_reg    <= dp_seen;
            m_updated_reg <= dp_updated;
            m_rate_reg    <= dp_rate;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_rate_reg};
    assign m_tuser  = {m_updated_reg, m_seen_reg};

    // a recomputed rate only comes with a compression
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
        else $error("rate update without compression");

    // one item at a time: no item taken right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in flight");

    // a result is never loaded over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten in output register");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the compression rate detector: a behavioral
// predictor follows every accepted sample and register write, and each result
// item is compared field by field against the oldest predicted result
// ----------------------------------------------------------------------------

module tb_top
    import crd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 30;    // well past the group-close latency
    localparam int FALL_SAT      = 65535;
    localparam int REPORT_MAX    = 10;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               seen;
        logic               updated;
        logic [NUMER_W-1:0] rate;
    } rate_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;   // [15:0] sample, [47:16] timestamp_ms
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // [19:0] rate, [23:20] zero
    logic [1:0]            m_tuser;          // [0] compression_seen, [1] rate_updated
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    compression_rate_detector_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor state: register copies and detector state
    // ------------------------------------------------------------------------
    logic [THRESH_W-1:0] cfg_fall_thresh = THRESH_RESET;
    logic [GROUP_W-1:0]  cfg_group_size  = GROUP_RESET;
    logic [NUMER_W-1:0]  cfg_rate_numer  = NUMER_RESET;

    int                  last_sample      = 0;
    int unsigned         fall_run         = 0;
    logic [GROUP_W-1:0]  strokes_in_group = '0;
    logic [TIME_W-1:0]   group_start_ms   = '0;
    logic [NUMER_W-1:0]  held_rate        = '0;

    rate_result_t        pending_results[$];
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;

    // stimulus knobs
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left      = 0;
    logic [TIME_W-1:0]   now_ms         = '0;

    // advance the detector copy by one sample and return the result it yields
    function automatic rate_result_t predict_rate(input logic [SAMPLE_W-1:0] smp,
                                                  input logic [TIME_W-1:0]   ts);
        int           cur;
        int unsigned  mag;
        logic [31:0]  span;
        rate_result_t res;
        cur = $signed(smp);
        mag = (cur < 0) ? -cur : cur;     // 32768 for the most negative sample
        res = '0;
        if (cur < last_sample && mag > cfg_fall_thresh) begin
            if (fall_run < FALL_SAT) fall_run++;
        end
        if (cur > last_sample && fall_run > 1) begin
            res.seen = 1'b1;
            fall_run = 0;
        end
        last_sample = cur;
        if (res.seen) begin
            strokes_in_group = strokes_in_group + 1'b1;
            if (strokes_in_group == 8'd1) group_start_ms = ts;
            // reaching or passing the size closes the group (size zero too)
            if (strokes_in_group >= cfg_group_size) begin
                span = ts - group_start_ms;
                strokes_in_group = '0;
                if (span == 0) held_rate = cfg_rate_numer;
                else held_rate = NUMER_W'({12'b0, cfg_rate_numer} / span);
                res.updated = 1'b1;
            end
        end
        res.rate = held_rate;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker, values sampled as they stood at the edge
    always @(posedge aclk) begin
        rate_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result item: seen=%0b upd=%0b rate=%0d",
                             m_tuser[0], m_tuser[1], m_tdata[19:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.seen || m_tuser[1] !== want.updated ||
                    m_tdata[19:0] !== want.rate) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"result mismatch: exp seen=%0b upd=%0b rate=%0d,",
                                  " got seen=%0b upd=%0b rate=%0d"},
                                 want.seen, want.updated, want.rate,
                                 m_tuser[0], m_tuser[1], m_tdata[19:0]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------

    // offer one sample after an optional random gap, predict on acceptance;
    // tvalid stays high afterwards, so it does not drop between back-to-back items
    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] ts);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, smp};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_rate(smp, ts));
    endtask

    // mostly 1 to 40 ms per sample, sometimes the same ms, sometimes a jump
    task automatic send_timed(input logic [SAMPLE_W-1:0] smp);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick >= 8) now_ms = now_ms + $urandom_range(1, 40);
        else if (pick >= 5) now_ms = $urandom;
        send_item(smp, now_ms);
    endtask

    // one register write; cfg_valid is left high for the next write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FALL_THRESHOLD: cfg_fall_thresh = val[THRESH_W-1:0];
            REG_GROUP_SIZE:     cfg_group_size  = val[GROUP_W-1:0];
            REG_RATE_NUMERATOR: cfg_rate_numer  = val[NUMER_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering items and let every result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write all three registers while the block is idle
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr,
                                  input logic [CFG_DATA_W-1:0] grp,
                                  input logic [CFG_DATA_W-1:0] numer);
        drain();
        write_reg(REG_FALL_THRESHOLD, thr);
        write_reg(REG_GROUP_SIZE, grp);
        write_reg(REG_RATE_NUMERATOR, numer);
        cfg_valid <= 1'b0;
    endtask

    // two falls then a rise, closing on the given timestamp
    task automatic send_compression(input logic [TIME_W-1:0] ts);
        send_item(16'sd600, ts - 1);
        send_item(-16'sd600, ts - 1);
        send_item(16'sd1500, ts);
    endtask

    // random strokes: a peak, one to five drops, one to three rises;
    // single drops and small magnitudes give broken strokes, plus raw noise
    task automatic run_strokes(input int n);
        int sent;
        int v;
        int step;
        int falls;
        int rises;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 15) begin
                send_timed(16'($urandom));
                sent++;
            end else begin
                v = $urandom_range(0, 32767);
                send_timed(16'(v));
                sent++;
                falls = $urandom_range(1, 5);
                repeat (falls) begin
                    step = $urandom_range(1, 9000);
                    v = v - step;
                    if (v < -32768) v = -32768;
                    send_timed(16'(v));
                    sent++;
                end
                rises = $urandom_range(1, 3);
                repeat (rises) begin
                    step = $urandom_range(1, 12000);
                    v = v + step;
                    if (v > 32767) v = 32767;
                    send_timed(16'(v));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes at the reset register values
    task automatic test_field_extremes();
        send_item(16'sh7FFF, 32'h0000_0000);
        send_item(16'sh8000, 32'hFFFF_FFFF);
        send_item(16'sh0000, 32'h0000_0001);   // rise after one fall only
        send_item(16'shFFFF, 32'h8000_0000);   // below threshold
        send_item(16'sh0001, 32'h7FFF_FFFF);
    endtask

    // largest threshold: only the most negative sample gets past it
    task automatic test_most_negative();
        apply_settings(20'hFFFFF, 20'd2, 20'd600000);   // threshold masks to 7FFF
        send_item(16'sh7FFF, 32'd100);
        send_item(-16'sd32767, 32'd101);
        send_item(16'sh8000, 32'd102);
        send_item(16'sh0000, 32'd103);
    endtask

    // two compressions on the same ms saturate the rate to the numerator
    task automatic test_zero_duration();
        drain();
        write_reg(REG_UNUSED, 20'h12345);
        apply_settings(20'd0, 20'd2, 20'hFFFFF);
        send_item(16'sd1500, 32'd990);
        send_compression(32'd1000);
        send_compression(32'd1000);
    endtask

    // group size zero closes on the first compression
    task automatic test_group_zero();
        apply_settings(20'd0, 20'hABC00, 20'd777);      // group size masks to zero
        send_item(16'sd1500, 32'd2000);
        send_compression(32'd2010);
    endtask

    // size lowered mid-group, the group spans the timestamp wrap
    task automatic test_group_lowered();
        apply_settings(20'd0, 20'd5, 20'd600000);
        send_item(16'sd1500, 32'hFFFF_FFE0);
        send_compression(32'hFFFF_FFF0);
        send_compression(32'hFFFF_FFF8);
        apply_settings(20'd0, 20'd1, 20'd600000);
        send_compression(32'h0000_0010);
    endtask

    task automatic test_random_no_idle();
        apply_settings(20'd2816, 20'd3, 20'd600000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        now_ms = $urandom;
        run_strokes(400);
    endtask

    task automatic test_random_sender_gaps();
        apply_settings(20'($urandom_range(0, 4000)), 20'($urandom_range(1, 6)),
                       20'($urandom_range(1, 20'hFFFFF)));
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        run_strokes(400);
    endtask

    // largest group never closes here; the next phase lowers it
    task automatic test_random_receiver_stalls();
        apply_settings(20'd0, 20'd255, 20'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_strokes(200);
    endtask

    task automatic test_random_both_idle();
        apply_settings(20'($urandom_range(0, 3000)), 20'd2, 20'hFFFFF);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_strokes(450);
    endtask

    // receiver holds off long enough that the block stalls its input
    task automatic test_output_backpressure();
        apply_settings(20'd1000, 20'd5, 20'($urandom_range(1, 20'hFFFFF)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        run_strokes(80);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_most_negative();
        test_zero_duration();
        test_group_zero();
        test_group_lowered();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_output_backpressure();

        drain();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
